/* rtl/core/apag_pkg.sv */
// ----------------------------------------------------------------------------
// apag_pkg - shared types and constants of the ATA partition access guard
// Request and result payloads, job record between front and back end,
// configuration bundle, task-file offsets and command codes.
// ----------------------------------------------------------------------------
package apag_pkg;

  localparam int unsigned LBA_WIDTH_DEF = 48;
  localparam int unsigned LBA_FULL_W    = 48;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 48;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IO_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_END   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_SEC   = 2'd3;

  localparam logic [15:0] IO_BASE_RST = 16'd496;

  // Task-file register offsets
  localparam logic [15:0] OFS_COUNT = 16'd2;
  localparam logic [15:0] OFS_LOW   = 16'd3;
  localparam logic [15:0] OFS_MID   = 16'd4;
  localparam logic [15:0] OFS_HIGH  = 16'd5;
  localparam logic [15:0] OFS_DRIVE = 16'd6;
  localparam logic [15:0] OFS_CMD   = 16'd7;

  // Command codes
  localparam logic [7:0] CMD_RD_DMA_EXT = 8'h25;
  localparam logic [7:0] CMD_WR_DMA_EXT = 8'h35;
  localparam logic [7:0] CMD_RD_DMA     = 8'hC8;
  localparam logic [7:0] CMD_WR_DMA     = 8'hCA;

  localparam int unsigned SLAVE_BIT       = 4;
  localparam logic [LBA_FULL_W-1:0] BOOT_LAST = 48'd63;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_INJECT = 2'd1,
    KIND_HALT   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_HALT,
    JOB_LBA48,
    JOB_LBA28
  } job_kind_e;

  typedef struct packed {
    logic [15:0] port;
    logic        is_write;
    logic        is_byte;
    logic [7:0]  data;
    logic [7:0]  drive_head_now;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_port;
    logic [7:0]  out_data;
    logic        last;
  } rsp_t;

  typedef struct packed {
    job_kind_e   jkind;
    logic [15:0] port;
    logic [7:0]  data;
    logic [7:0]  dh;
    logic [7:0]  cnt0;   // LBA48: count slot 0
    logic [7:0]  cnt1;   // LBA48: count slot 1, LBA28: latest count
  } job_t;

  typedef struct packed {
    logic [15:0]           io_base;
    logic [LBA_FULL_W-1:0] part_start;
    logic [LBA_FULL_W-1:0] part_end;
    logic [LBA_FULL_W-1:0] null_sector;
  } cfg_t;

endpackage

/* rtl/core/apag_front.sv */
// ----------------------------------------------------------------------------
// apag_front - request classifier and task-file shadow
// Classifies each request, keeps the two-deep shadow of count and LBA byte
// writes, and hands a job with its assembled LBA to the queue.
// ----------------------------------------------------------------------------
module apag_front import apag_pkg::*; #(
  parameter int unsigned LbaWidth = LBA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         io_base_i,
  input  logic                in_valid_i,
  input  req_t                in_req_i,
  input  logic                q_full_i,
  output logic                push_o,
  output job_t                job_o,
  output logic [LbaWidth-1:0] lba_o
);

  localparam int unsigned NUM_SH = 4;
  localparam int unsigned SH_COUNT = 0;
  localparam int unsigned SH_LOW   = 1;
  localparam int unsigned SH_MID   = 2;
  localparam int unsigned SH_HIGH  = 3;

  logic [7:0] hist_q [NUM_SH][2];
  logic [1:0] nwr_q  [NUM_SH];
  logic [7:0] latest [NUM_SH];
  logic [NUM_SH-1:0] sh_hit;
  logic              active;
  logic              cmd_hit;
  logic [15:0]       cmd_port;
  logic [LBA_FULL_W-1:0] lba48;
  logic [27:0]           lba28;

  assign push_o = in_valid_i && !q_full_i;
  assign active = in_req_i.is_byte && in_req_i.is_write &&
                  !in_req_i.drive_head_now[SLAVE_BIT];
  assign cmd_port = io_base_i + OFS_CMD;
  assign cmd_hit  = active && (in_req_i.port == cmd_port);

  always_comb begin
    for (int i = 0; i < NUM_SH; i++) begin
      sh_hit[i] = active && (in_req_i.port == 16'(io_base_i + OFS_COUNT + 16'(i)));
      if (nwr_q[i] == 2'd0) begin
        latest[i] = 8'h00;
      end else if (nwr_q[i] == 2'd1) begin
        latest[i] = hist_q[i][0];
      end else begin
        latest[i] = hist_q[i][1];
      end
    end
  end

  assign lba48 = {hist_q[SH_HIGH][0], hist_q[SH_MID][0], hist_q[SH_LOW][0],
                  hist_q[SH_HIGH][1], hist_q[SH_MID][1], hist_q[SH_LOW][1]};
  assign lba28 = {in_req_i.drive_head_now[3:0], latest[SH_HIGH], latest[SH_MID],
                  latest[SH_LOW]};

  always_comb begin
    job_o.port  = in_req_i.port;
    job_o.data  = in_req_i.data;
    job_o.dh    = in_req_i.drive_head_now;
    job_o.cnt0  = hist_q[SH_COUNT][0];
    job_o.cnt1  = hist_q[SH_COUNT][1];
    job_o.jkind = JOB_PASS;
    lba_o       = lba48[LbaWidth-1:0];
    if (!in_req_i.is_byte) begin
      job_o.jkind = JOB_HALT;
    end else if (cmd_hit) begin
      unique case (in_req_i.data) inside
        CMD_RD_DMA_EXT, CMD_WR_DMA_EXT: job_o.jkind = JOB_LBA48;
        CMD_RD_DMA, CMD_WR_DMA: begin
          job_o.jkind = JOB_LBA28;
          job_o.cnt1  = latest[SH_COUNT];
          lba_o       = LbaWidth'(lba28);
        end
        default: job_o.jkind = JOB_PASS;
      endcase
    end
  end

  // Shift history on a full shadow, clear everything on a command write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SH; i++) begin
        hist_q[i][0] <= 8'h00;
        hist_q[i][1] <= 8'h00;
        nwr_q[i]     <= 2'd0;
      end
    end else if (push_o) begin
      for (int i = 0; i < NUM_SH; i++) begin
        if (cmd_hit) begin
          hist_q[i][0] <= 8'h00;
          hist_q[i][1] <= 8'h00;
          nwr_q[i]     <= 2'd0;
        end else if (sh_hit[i]) begin
          if (nwr_q[i] == 2'd2) begin
            hist_q[i][0] <= hist_q[i][1];
            hist_q[i][1] <= in_req_i.data;
          end else begin
            hist_q[i][nwr_q[i][0]] <= in_req_i.data;
            nwr_q[i] <= nwr_q[i] + 2'd1;
          end
        end
      end
    end
  end

endmodule

/* rtl/core/apag_fifo.sv */
// ----------------------------------------------------------------------------
// apag_fifo - job queue between front and back end
// Short first-in first-out store of classified jobs and their LBAs.
// ----------------------------------------------------------------------------
module apag_fifo import apag_pkg::*; #(
  parameter int unsigned LbaWidth = LBA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  job_t                job_i,
  input  logic [LbaWidth-1:0] lba_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output job_t                job_o,
  output logic [LbaWidth-1:0] lba_o
);

  job_t                job_mem [QUEUE_DEPTH];
  logic [LbaWidth-1:0] lba_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = job_mem[rd_ptr_q];
  assign lba_o   = lba_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_mem[wr_ptr_q] <= job_i;
      lba_mem[wr_ptr_q] <= lba_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("job queue count above depth");

endmodule

/* rtl/core/apag_back.sv */
// ----------------------------------------------------------------------------
// apag_back - result sequencer
// Checks the job LBA against the window and emits the rewrite writes and
// the final pass or halt item through an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module apag_back import apag_pkg::*; #(
  parameter int unsigned LbaWidth = LBA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                head_valid_i,
  input  job_t                head_job_i,
  input  logic [LbaWidth-1:0] head_lba_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output rsp_t                out_rsp_o,
  input  logic                out_stall_i
);

  localparam logic [3:0] STEP_LAST48 = 4'd8;
  localparam logic [3:0] STEP_LAST28 = 4'd5;

  logic [3:0]            step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  rsp_q, item;
  logic                  load;
  logic                  oob;
  logic [LBA_FULL_W-1:0] lba;
  logic [LBA_FULL_W-1:0] ns;
  logic [15:0]           p_count, p_low, p_mid, p_high, p_drive;

  assign lba = LBA_FULL_W'(head_lba_i);
  assign oob = !(((lba >= cfg_i.part_start) && (lba <= cfg_i.part_end)) ||
                 (lba <= BOOT_LAST));
  assign ns  = cfg_i.null_sector;

  assign p_count = cfg_i.io_base + OFS_COUNT;
  assign p_low   = cfg_i.io_base + OFS_LOW;
  assign p_mid   = cfg_i.io_base + OFS_MID;
  assign p_high  = cfg_i.io_base + OFS_HIGH;
  assign p_drive = cfg_i.io_base + OFS_DRIVE;

  always_comb begin
    item.kind     = KIND_PASS;
    item.out_port = head_job_i.port;
    item.out_data = head_job_i.data;
    item.last     = 1'b1;
    unique case (head_job_i.jkind)
      JOB_HALT: item.kind = KIND_HALT;
      JOB_LBA48: begin
        if (oob && step_q != STEP_LAST48) begin
          item.kind = KIND_INJECT;
          item.last = 1'b0;
          case (step_q)
            4'd0: begin item.out_port = p_count; item.out_data = head_job_i.cnt0; end
            4'd1: begin item.out_port = p_low;   item.out_data = ns[31:24];       end
            4'd2: begin item.out_port = p_mid;   item.out_data = ns[39:32];       end
            4'd3: begin item.out_port = p_high;  item.out_data = ns[47:40];       end
            4'd4: begin item.out_port = p_count; item.out_data = head_job_i.cnt1; end
            4'd5: begin item.out_port = p_low;   item.out_data = ns[7:0];         end
            4'd6: begin item.out_port = p_mid;   item.out_data = ns[15:8];        end
            default: begin item.out_port = p_high; item.out_data = ns[23:16];     end
          endcase
        end
      end
      JOB_LBA28: begin
        if (oob && step_q != STEP_LAST28) begin
          item.kind = KIND_INJECT;
          item.last = 1'b0;
          case (step_q)
            4'd0: begin
              item.out_port = p_drive;
              item.out_data = {head_job_i.dh[7:4], ns[27:24]};
            end
            4'd1: begin item.out_port = p_count; item.out_data = head_job_i.cnt1; end
            4'd2: begin item.out_port = p_high;  item.out_data = ns[23:16];       end
            4'd3: begin item.out_port = p_mid;   item.out_data = ns[15:8];        end
            default: begin item.out_port = p_low; item.out_data = ns[7:0];        end
          endcase
        end
      end
      default: item.kind = KIND_PASS;
    endcase
  end

  // Advance one item whenever the output register is free or drains
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && item.last;

  always_comb begin
    out_valid_d = load || (out_valid_q && out_stall_i);
    if (pop_o) begin
      step_d = '0;
    end else if (load) begin
      step_d = step_q + 4'd1;
    end else begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_LAST48)
    else $error("sequencer step out of range");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> step_q == '0)
    else $error("sequencer mid-job with empty queue");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_o && out_rsp_o.last)
    else $error("job retired without a final item");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.kind != 2'd3)
    else $error("result kind undefined");

endmodule

/* rtl/core/ata_partition_access_guard.sv */
// ----------------------------------------------------------------------------
// ata_partition_access_guard - ATA task-file access guard, top level
// Holds the configuration registers and joins front end, queue and back end.
// ----------------------------------------------------------------------------
// Per trapped port access the back-end sequencer yields one result item per cycle
// while the output is not stalled: one item for a plain access, six for a
// redirected LBA28 DMA command (five rewrite writes plus the command) and nine
// for a redirected LBA48 DMA EXT command (eight rewrite writes plus the command).
// The front end takes a new request every cycle while the two-entry job queue has room, so
// shadowing of count and LBA writes runs ahead of a long rewrite burst. The LBA bound check
// is done on the queue head; the user must write the registers only while idle, unenforced by the block.
module ata_partition_access_guard import apag_pkg::*; #(
  parameter int unsigned LBA_WIDTH = LBA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  req_t                  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rsp_t                  out_rsp_o
);

  cfg_t                 cfg_q;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 head_valid;
  job_t                 push_job, head_job;
  logic [LBA_WIDTH-1:0] push_lba, head_lba;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.io_base     <= IO_BASE_RST;
      cfg_q.part_start  <= '0;
      cfg_q.part_end    <= '0;
      cfg_q.null_sector <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IO_BASE:    cfg_q.io_base     <= cfg_data_i[15:0];
        CFG_PART_START: cfg_q.part_start  <= cfg_data_i[LBA_FULL_W-1:0];
        CFG_PART_END:   cfg_q.part_end    <= cfg_data_i[LBA_FULL_W-1:0];
        CFG_NULL_SEC:   cfg_q.null_sector <= cfg_data_i[LBA_FULL_W-1:0];
        default:        cfg_q.io_base     <= cfg_q.io_base;
      endcase
    end
  end

  assign in_stall_o = q_full;

  apag_front #(.LbaWidth(LBA_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .io_base_i  (cfg_q.io_base),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job),
    .lba_o      (push_lba)
  );

  apag_fifo #(.LbaWidth(LBA_WIDTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .lba_i   (push_lba),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (head_valid),
    .job_o   (head_job),
    .lba_o   (head_lba)
  );

  apag_back #(.LbaWidth(LBA_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .head_lba_i   (head_lba),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_rsp_o    (out_rsp_o),
    .out_stall_i  (out_stall_i)
  );

endmodule
